// File: sv/lyrt_pkg.sv
// shared types and constants of the ramp timeline
// no dependencies; imported by every module of the block
`default_nettype none

package lyrt_pkg;

   // fixed-point and time widths
   localparam int FRAC_BITS = 16;
   localparam int TIME_BITS = 32;
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam int DUR_W     = 24;
   localparam int LOOP_W    = 16;
   localparam int CSR_W     = 24;
   localparam int DIV_CNT_W = $clog2(FRAC_BITS);

   localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_BITS - 1);

   // request codes
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_PLAY   = 3'd1;
   localparam logic [2:0] REQ_PAUSE  = 3'd2;
   localparam logic [2:0] REQ_RESUME = 3'd3;
   localparam logic [2:0] REQ_STOP   = 3'd4;
   localparam logic [2:0] REQ_CANCEL = 3'd5;

   // event codes
   localparam logic [1:0] EVT_NONE     = 2'd0;
   localparam logic [1:0] EVT_STARTED  = 2'd1;
   localparam logic [1:0] EVT_FINISHED = 2'd2;
   localparam logic [1:0] EVT_CANCEL   = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_DURATION = 2'd0;
   localparam logic [1:0] CSR_DELAY    = 2'd1;
   localparam logic [1:0] CSR_LOOPS    = 2'd2;
   localparam logic [1:0] CSR_YOYO     = 2'd3;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [TIME_BITS-1:0] now_ms;
   } lyrt_req_type;

   typedef struct packed {
      logic [VAL_W-1:0] ramp_value;
      logic             value_valid;
      logic [VAL_W-1:0] time_progress;
      logic             is_live;
      logic             is_paused;
      logic             going_back;
      logic [1:0]       event_code;
   } lyrt_rsp_type;

   typedef struct packed {
      logic [DUR_W-1:0]         leg_len;
      logic [DUR_W-1:0]         lead_wait;
      logic signed [LOOP_W-1:0] run_count;
      logic                     yoyo_enable;
   } lyrt_cfg_type;

   // status of the fraction unit
   typedef struct packed {
      logic             done;
      logic             early;
      logic [VAL_W-1:0] value;
   } lyrt_frac_sts_type;

endpackage

`default_nettype wire

// File: sv/lyrt_csr.sv
// configuration registers of the ramp timeline
// depends on lyrt_pkg
`default_nettype none

module lyrt_csr import lyrt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output lyrt_cfg_type          cfg
);

   lyrt_cfg_type cfg_ff;

   // register write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leg_len     <= '0;
         cfg_ff.lead_wait   <= '0;
         cfg_ff.run_count   <= LOOP_W'(1);
         cfg_ff.yoyo_enable <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DURATION: cfg_ff.leg_len     <= csr_wdata[DUR_W-1:0];
            CSR_DELAY:    cfg_ff.lead_wait   <= csr_wdata[DUR_W-1:0];
            CSR_LOOPS:    cfg_ff.run_count   <= csr_wdata[LOOP_W-1:0];
            CSR_YOYO:     cfg_ff.yoyo_enable <= csr_wdata[0];
            default:      cfg_ff.yoyo_enable <= cfg_ff.yoyo_enable;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/lyrt_frac.sv
// leg fraction unit: (t - delay) / duration in Q1.16, saturated to one
// bit-serial restoring divider, one quotient bit a cycle; depends on lyrt_pkg
`default_nettype none

module lyrt_frac import lyrt_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [TIME_BITS-1:0] t,
   input  wire logic [DUR_W-1:0]     delay,
   input  wire logic [DUR_W-1:0]     dur,
   output lyrt_frac_sts_type         sts
);

   typedef enum logic [1:0] {F_IDLE, F_CHECK, F_DIV} fstate_type;

   fstate_type             state_ff;
   logic [TIME_BITS-1:0]   e_ff;
   logic                   early_ff;
   logic [DUR_W-1:0]       d_ff;
   logic [DUR_W-1:0]       r_ff;
   logic [FRAC_BITS-2:0]   q_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [VAL_W-1:0]       val_ff;
   logic                   done_ff;

   logic [TIME_BITS:0]     sub;
   logic [DUR_W+1:0]       step_diff;
   logic                   step_bit;
   logic [DUR_W-1:0]       step_rem;

   // elapsed time past the delay, borrow marks a tick still in the delay
   assign sub = {1'b0, t} - (TIME_BITS+1)'(delay);

   // one restoring step: shift remainder, try the divisor
   assign step_diff = {1'b0, r_ff, 1'b0} - {2'b00, d_ff};
   assign step_bit  = ~step_diff[DUR_W+1];
   assign step_rem  = step_bit ? step_diff[DUR_W-1:0] : {r_ff[DUR_W-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            F_IDLE: begin
               if (start) begin
                  e_ff     <= sub[TIME_BITS-1:0];
                  early_ff <= sub[TIME_BITS];
                  d_ff     <= (dur == '0) ? DUR_W'(1) : dur;
                  state_ff <= F_CHECK;
               end
            end
            F_CHECK: begin
               if (early_ff) begin
                  val_ff   <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= F_IDLE;
               end else if (e_ff >= TIME_BITS'(d_ff)) begin
                  val_ff   <= ONE_Q;
                  done_ff  <= 1'b1;
                  state_ff <= F_IDLE;
               end else begin
                  // e below d, so it fits the remainder
                  r_ff     <= e_ff[DUR_W-1:0];
                  cnt_ff   <= '0;
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               r_ff   <= step_rem;
               q_ff   <= {q_ff[FRAC_BITS-3:0], step_bit};
               cnt_ff <= cnt_ff + DIV_CNT_W'(1);
               if (cnt_ff == DIV_LAST) begin
                  val_ff   <= {1'b0, q_ff, step_bit};
                  done_ff  <= 1'b1;
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign sts.done  = done_ff;
   assign sts.early = early_ff;
   assign sts.value = val_ff;

endmodule

`default_nettype wire

// File: sv/loop_yoyo_ramp_timeline.sv
// ramp timeline with start delay, loop count and yoyo legs
// depends on lyrt_pkg, lyrt_csr, lyrt_frac
//
//   port group   direction  handshake          payload
//   req_         in         req_valid/stall    lyrt_req_type (request, now_ms)
//   rsp_         out        rsp_valid/stall    lyrt_rsp_type (one per item)
//   csr_         in         csr_we             csr_index, csr_wdata
//
// one item at a time: after accept the item runs through time, start, wait and
// commit; the fraction comes from the 16-step serial divider in lyrt_frac, or is
// settled by the delay or saturation check alone
// the next item is accepted while a result waits in the output register
// synchronous active-high reset clears run state and the registers to defaults
// a stalled result holds the item before commit until the output drains
`default_nettype none

module loop_yoyo_ramp_timeline import lyrt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire lyrt_req_type     req_item,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      lyrt_rsp_type     rsp_item,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {S_IDLE, S_TIME, S_START, S_WAIT, S_COMMIT} state_type;

   state_type            state_ff;
   lyrt_req_type         req_ff;
   logic [TIME_BITS-1:0] t_ff;
   lyrt_rsp_type         rsp_ff;
   logic                 rsp_valid_ff;

   // run state
   logic [TIME_BITS-1:0] leg_start_ff, leg_start_in;
   logic [TIME_BITS-1:0] banked_ff, banked_in;
   logic                 active_ff, active_in;
   logic                 paused_ff, paused_in;
   logic                 rev_ff, rev_in;
   logic [LOOP_W-1:0]    loops_ff, loops_in;
   logic                 forever_ff, forever_in;
   logic [VAL_W-1:0]     cache_ff, cache_in;
   logic [DUR_W-1:0]     run_dur_ff, run_dur_in;
   logic [DUR_W-1:0]     run_delay_ff, run_delay_in;
   logic                 run_yoyo_ff, run_yoyo_in;
   lyrt_rsp_type         rsp_in;

   lyrt_cfg_type         cfg;
   lyrt_frac_sts_type    frac_sts;
   logic                 commit;

   lyrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lyrt_frac u_frac (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_START),
      .t     (t_ff),
      .delay (run_delay_ff),
      .dur   (run_dur_ff),
      .sts   (frac_sts)
   );

   // next run state and result from the request and the leg fraction
   always_comb begin
      logic             counted;
      logic             ended;
      logic             zero_prog;
      logic [VAL_W-1:0] ramp;
      logic             valid;
      logic [1:0]       evt;
      logic [LOOP_W:0]  half_sum;

      leg_start_in = leg_start_ff;
      banked_in    = banked_ff;
      active_in    = active_ff;
      paused_in    = paused_ff;
      rev_in       = rev_ff;
      loops_in     = loops_ff;
      forever_in   = forever_ff;
      cache_in     = cache_ff;
      run_dur_in   = run_dur_ff;
      run_delay_in = run_delay_ff;
      run_yoyo_in  = run_yoyo_ff;
      counted      = 1'b1;
      ended        = 1'b0;
      zero_prog    = 1'b0;
      ramp         = '0;
      valid        = 1'b0;
      evt          = EVT_NONE;
      half_sum     = {1'b0, cfg.run_count} + (LOOP_W+1)'(1);

      unique case (req_ff.req_type)
         REQ_TICK: begin
            if (active_ff && !paused_ff && !frac_sts.early) begin
               valid = 1'b1;
               ramp  = rev_ff ? ONE_Q - frac_sts.value : frac_sts.value;
               // leg end: flip or count down
               if (frac_sts.value == ONE_Q) begin
                  if (run_yoyo_ff) begin
                     rev_in  = !rev_ff;
                     counted = rev_ff;
                  end
                  if (counted && !forever_ff) begin
                     if (loops_ff <= LOOP_W'(1)) begin
                        loops_in  = '0;
                        active_in = 1'b0;
                        paused_in = 1'b0;
                        cache_in  = ONE_Q;
                        evt       = EVT_FINISHED;
                        ended     = 1'b1;
                     end else begin
                        loops_in = loops_ff - LOOP_W'(1);
                     end
                  end
                  if (!ended) begin
                     leg_start_in = req_ff.now_ms;
                     banked_in    = '0;
                     zero_prog    = 1'b1;
                  end
               end
            end
         end
         REQ_PLAY: begin
            run_dur_in   = cfg.leg_len;
            run_delay_in = cfg.lead_wait;
            run_yoyo_in  = cfg.yoyo_enable;
            forever_in   = cfg.run_count[LOOP_W-1];
            if (cfg.run_count[LOOP_W-1]) begin
               loops_in = '0;
            end else if (cfg.yoyo_enable) begin
               loops_in = half_sum[LOOP_W:1];
            end else begin
               loops_in = cfg.run_count;
            end
            cache_in     = '0;
            leg_start_in = req_ff.now_ms;
            banked_in    = '0;
            rev_in       = 1'b0;
            paused_in    = 1'b0;
            active_in    = 1'b1;
            zero_prog    = 1'b1;
            evt          = EVT_STARTED;
         end
         REQ_PAUSE: begin
            if (active_ff && !paused_ff) begin
               banked_in = t_ff;
               paused_in = 1'b1;
            end
         end
         REQ_RESUME: begin
            if (active_ff && paused_ff) begin
               leg_start_in = req_ff.now_ms;
               paused_in    = 1'b0;
            end
         end
         REQ_STOP: begin
            if (active_ff) begin
               active_in = 1'b0;
               paused_in = 1'b0;
               cache_in  = ONE_Q;
               evt       = EVT_FINISHED;
            end
         end
         REQ_CANCEL: begin
            if (active_ff) begin
               active_in = 1'b0;
               paused_in = 1'b0;
               cache_in  = frac_sts.value;
               evt       = EVT_CANCEL;
            end
         end
         default: evt = EVT_NONE;
      endcase

      rsp_in.ramp_value    = ramp;
      rsp_in.value_valid   = valid;
      rsp_in.time_progress = active_in ? (zero_prog ? '0 : frac_sts.value) : cache_in;
      rsp_in.is_live       = active_in;
      rsp_in.is_paused     = active_in && paused_in;
      rsp_in.going_back    = active_in && rev_in;
      rsp_in.event_code    = evt;
   end

   assign commit = (state_ff == S_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   // sequencer, run state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         leg_start_ff <= '0;
         banked_ff    <= '0;
         active_ff    <= 1'b0;
         paused_ff    <= 1'b0;
         rev_ff       <= 1'b0;
         loops_ff     <= '0;
         forever_ff   <= 1'b0;
         cache_ff     <= '0;
         run_dur_ff   <= '0;
         run_delay_ff <= '0;
         run_yoyo_ff  <= 1'b0;
      end else begin
         // output register: filled on commit, emptied when its item is taken
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_item;
                  state_ff <= S_TIME;
               end
            end
            S_TIME: begin
               // run time of the live leg
               t_ff     <= paused_ff ? banked_ff
                                     : banked_ff + req_ff.now_ms - leg_start_ff;
               state_ff <= S_START;
            end
            S_START: state_ff <= S_WAIT;
            S_WAIT: begin
               if (frac_sts.done) begin
                  state_ff <= S_COMMIT;
               end
            end
            S_COMMIT: begin
               if (commit) begin
                  leg_start_ff <= leg_start_in;
                  banked_ff    <= banked_in;
                  active_ff    <= active_in;
                  paused_ff    <= paused_in;
                  rev_ff       <= rev_in;
                  loops_ff     <= loops_in;
                  forever_ff   <= forever_in;
                  cache_ff     <= cache_in;
                  run_dur_ff   <= run_dur_in;
                  run_delay_ff <= run_delay_in;
                  run_yoyo_ff  <= run_yoyo_in;
                  rsp_ff       <= rsp_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // an accepted item starts the time step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_TIME)
      else $error("accepted item did not start processing");

   // the fraction unit reports only while the sequencer waits for it
   a_frac_done_wait: assert property (@(posedge clock) disable iff (reset)
      frac_sts.done |-> state_ff == S_WAIT)
      else $error("fraction done outside wait");

   // the fraction never exceeds one
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      frac_sts.done |-> frac_sts.value <= ONE_Q)
      else $error("fraction above one");

   // no value means a zero ramp
   a_ramp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.value_valid |-> rsp_item.ramp_value == '0)
      else $error("ramp value without valid flag");

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for loop_yoyo_ramp_timeline: directed table, then random run phases
// depends on lyrt_pkg and the timeline rtl; every result is checked against an in-file predictor or a fixed row
`default_nettype none

module tb;
   import lyrt_pkg::*;

   localparam int CLK_PERIOD      = 8;
   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 30;
   localparam int HOLD_CYCLES     = 400;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int RANDOM_PHASES   = 20;
   localparam int ITEMS_PER_PHASE = 45;

   // request codes the block must ignore
   localparam logic [2:0] REQ_BAD_LO = 3'd6;
   localparam logic [2:0] REQ_BAD_HI = 3'd7;

   // receiver stall patterns
   localparam int STALL_NONE  = 0;
   localparam int STALL_LIGHT = 1;
   localparam int STALL_HEAVY = 2;
   localparam int STALL_BEAT  = 3;

   localparam lyrt_rsp_type QUIET_RSP = '0;

   typedef struct {
      bit                 is_cfg;
      logic [DUR_W-1:0]   dur;
      logic [DUR_W-1:0]   dly;
      logic [LOOP_W-1:0]  loops;
      bit                 yoyo;
      lyrt_req_type       item;
      bit                 typed;
      lyrt_rsp_type       want;
   } plan_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lyrt_req_type     req_item  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lyrt_rsp_type     rsp_item;
   logic             csr_we    = 1'b0;
   logic [1:0]       csr_index = CSR_DURATION;
   logic [CSR_W-1:0] csr_wdata = '0;

   // register copies seen by the predictor
   logic [DUR_W-1:0]  cfg_dur;
   logic [DUR_W-1:0]  cfg_delay;
   logic [LOOP_W-1:0] cfg_loops;
   bit                cfg_yoyo;

   // predictor state
   logic [TIME_BITS-1:0] tl_leg_start;
   logic [TIME_BITS-1:0] tl_banked;
   bit                   tl_active;
   bit                   tl_paused;
   bit                   tl_reverse;
   logic [LOOP_W-1:0]    tl_loops_left;
   bit                   tl_forever;
   logic [VAL_W-1:0]     tl_cache;
   logic [DUR_W-1:0]     tl_dur;
   logic [DUR_W-1:0]     tl_delay;
   bit                   tl_yoyo;

   lyrt_rsp_type pending_rsp[$];
   plan_row_type plan[$];
   int           mismatches = 0;
   int           burst_left = 0;
   int           hold_asked = 0;

   // receiver side state
   lyrt_rsp_type rsp_want;
   int           hold_done  = 0;
   int           hold_left  = 0;
   int           stall_mode = STALL_NONE;
   int           mode_left  = 0;
   int           rsp_cycle  = 0;
   logic         stall_next;

   loop_yoyo_ramp_timeline u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // truncated leg fraction in q1.16, saturated to one
   function automatic logic [VAL_W-1:0] leg_fraction(input logic [TIME_BITS-1:0] t,
                                                     input logic [DUR_W-1:0] start_at,
                                                     input logic [DUR_W-1:0] dur);
      logic [TIME_BITS-1:0] span;
      logic [TIME_BITS-1:0] el;
      logic [47:0]          quot;
      span = (dur == '0) ? 32'd1 : 32'(dur);
      if (t < 32'(start_at)) return '0;
      el = t - 32'(start_at);
      if (el >= span) return ONE_Q;
      quot = {el, 16'b0} / 48'(span);
      return quot[VAL_W-1:0];
   endfunction

   // forward progress of the live run, or the cached value when idle
   function automatic logic [VAL_W-1:0] progress_now(input logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] run;
      if (!tl_active) return tl_cache;
      run = tl_paused ? tl_banked : tl_banked + now - tl_leg_start;
      return leg_fraction(run, tl_delay, tl_dur);
   endfunction

   function automatic void timeline_reset();
      cfg_dur       = '0;
      cfg_delay     = '0;
      cfg_loops     = 16'd1;
      cfg_yoyo      = 1'b0;
      tl_leg_start  = '0;
      tl_banked     = '0;
      tl_active     = 1'b0;
      tl_paused     = 1'b0;
      tl_reverse    = 1'b0;
      tl_loops_left = '0;
      tl_forever    = 1'b0;
      tl_cache      = '0;
      tl_dur        = '0;
      tl_delay      = '0;
      tl_yoyo       = 1'b0;
   endfunction

   // applies one item to the predictor state and returns its result
   function automatic lyrt_rsp_type timeline_step(input lyrt_req_type it);
      lyrt_rsp_type         r;
      logic [TIME_BITS-1:0] now;
      logic [TIME_BITS-1:0] local_t;
      logic [VAL_W-1:0]     lp;
      logic [VAL_W-1:0]     ramp;
      bit                   valid;
      bit                   counted;
      logic [1:0]           ev;
      now   = it.now_ms;
      ramp  = '0;
      valid = 1'b0;
      ev    = EVT_NONE;
      case (it.req_type)
         REQ_TICK: begin
            if (tl_active && !tl_paused) begin
               local_t = now - tl_leg_start + tl_banked;
               if (local_t >= 32'(tl_delay)) begin
                  lp    = leg_fraction(local_t, tl_delay, tl_dur);
                  ramp  = tl_reverse ? ONE_Q - lp : lp;
                  valid = 1'b1;
                  if (lp >= ONE_Q) begin
                     counted = 1'b1;
                     if (tl_yoyo) begin
                        tl_reverse = !tl_reverse;
                        counted    = !tl_reverse;
                     end
                     if (counted && !tl_forever && tl_loops_left <= 16'd1) begin
                        // last leg ran out: finish without restarting the leg
                        tl_loops_left = '0;
                        tl_active     = 1'b0;
                        tl_paused     = 1'b0;
                        tl_cache      = ONE_Q;
                        ev            = EVT_FINISHED;
                     end else begin
                        if (counted && !tl_forever) tl_loops_left = tl_loops_left - 16'd1;
                        tl_leg_start = now;
                        tl_banked    = '0;
                     end
                  end
               end
            end
         end
         REQ_PLAY: begin
            tl_dur     = cfg_dur;
            tl_delay   = cfg_delay;
            tl_yoyo    = cfg_yoyo;
            tl_forever = cfg_loops[LOOP_W-1];
            if (cfg_loops[LOOP_W-1]) tl_loops_left = '0;
            else if (cfg_yoyo) tl_loops_left = 16'((17'(cfg_loops) + 17'd1) >> 1);
            else tl_loops_left = cfg_loops;
            tl_cache     = '0;
            tl_leg_start = now;
            tl_banked    = '0;
            tl_reverse   = 1'b0;
            tl_paused    = 1'b0;
            tl_active    = 1'b1;
            ev           = EVT_STARTED;
         end
         REQ_PAUSE: begin
            if (tl_active && !tl_paused) begin
               tl_banked = tl_banked + now - tl_leg_start;
               tl_paused = 1'b1;
            end
         end
         REQ_RESUME: begin
            if (tl_active && tl_paused) begin
               tl_leg_start = now;
               tl_paused    = 1'b0;
            end
         end
         REQ_STOP: begin
            if (tl_active) begin
               tl_active = 1'b0;
               tl_paused = 1'b0;
               tl_cache  = ONE_Q;
               ev        = EVT_FINISHED;
            end
         end
         REQ_CANCEL: begin
            if (tl_active) begin
               tl_cache  = progress_now(now);
               tl_active = 1'b0;
               tl_paused = 1'b0;
               ev        = EVT_CANCEL;
            end
         end
         default: ;
      endcase
      r.ramp_value    = ramp;
      r.value_valid   = valid;
      r.time_progress = progress_now(now);
      r.is_live       = tl_active;
      r.is_paused     = tl_active && tl_paused;
      r.going_back    = tl_active && tl_reverse;
      r.event_code    = ev;
      return r;
   endfunction

   function automatic lyrt_rsp_type rsp_of(input logic [VAL_W-1:0] ramp, input logic valid,
                                           input logic [VAL_W-1:0] tp, input logic live,
                                           input logic paused, input logic back,
                                           input logic [1:0] ev);
      lyrt_rsp_type r;
      r.ramp_value    = ramp;
      r.value_valid   = valid;
      r.time_progress = tp;
      r.is_live       = live;
      r.is_paused     = paused;
      r.going_back    = back;
      r.event_code    = ev;
      return r;
   endfunction

   function automatic plan_row_type fixed_row(input logic [2:0] rq,
                                              input logic [TIME_BITS-1:0] now,
                                              input lyrt_rsp_type want);
      plan_row_type row;
      row = '{default: '0};
      row.item.req_type = rq;
      row.item.now_ms   = now;
      row.typed         = 1'b1;
      row.want          = want;
      return row;
   endfunction

   function automatic plan_row_type req_row(input logic [2:0] rq,
                                            input logic [TIME_BITS-1:0] now);
      plan_row_type row;
      row       = fixed_row(rq, now, QUIET_RSP);
      row.typed = 1'b0;
      return row;
   endfunction

   function automatic plan_row_type cfg_row(input logic [DUR_W-1:0] dur,
                                            input logic [DUR_W-1:0] dly,
                                            input logic [LOOP_W-1:0] loops, input bit yoyo);
      plan_row_type row;
      row        = '{default: '0};
      row.is_cfg = 1'b1;
      row.dur    = dur;
      row.dly    = dly;
      row.loops  = loops;
      row.yoyo   = yoyo;
      return row;
   endfunction

   // stop offering and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_DURATION: cfg_dur   = data;
         CSR_DELAY:    cfg_delay = data;
         CSR_LOOPS:    cfg_loops = data[LOOP_W-1:0];
         CSR_YOYO:     cfg_yoyo  = data[0];
         default: ;
      endcase
   endtask

   // registers change only once the block has gone quiet
   task automatic set_config(input logic [DUR_W-1:0] dur, input logic [DUR_W-1:0] dly,
                             input logic [LOOP_W-1:0] loops, input bit yoyo);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(CSR_DURATION, dur);
      write_reg(CSR_DELAY, dly);
      write_reg(CSR_LOOPS, {8'($urandom_range(0, 255)), loops});
      write_reg(CSR_YOYO, {23'($urandom), yoyo});
   endtask

   // send one item in bursts with random gaps, then record its expected result
   task automatic offer(input lyrt_req_type it, input bit typed, input lyrt_rsp_type fixed);
      lyrt_rsp_type predicted;
      int           gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 30);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      predicted = timeline_step(it);
      pending_rsp.push_back(typed ? fixed : predicted);
   endtask

   // one random run phase: a setting, then mostly well-formed command streams
   task automatic run_phase(input int phase, input int n_items);
      logic [DUR_W-1:0]     dur;
      logic [DUR_W-1:0]     dly;
      logic [LOOP_W-1:0]    loops;
      bit                   yoyo;
      logic [TIME_BITS-1:0] now_t;
      logic [TIME_BITS-1:0] step;
      lyrt_req_type         it;
      int                   pick;
      int                   reach;
      case (phase)
         0: begin dur = '0;          dly = '0;          loops = 16'hFFFF; yoyo = 1'b1; end
         1: begin dur = 24'hFFFFFF;  dly = 24'hFFFFFF;  loops = 16'h7FFF; yoyo = 1'b0; end
         2: begin dur = 24'd1;       dly = '0;          loops = 16'h8000; yoyo = 1'b0; end
         3: begin
            dur = 24'($urandom_range(1, 50));
            dly = 24'($urandom_range(0, 20));
            loops = '0;
            yoyo = 1'b1;
         end
         default: begin
            dur = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
            case ($urandom_range(0, 5))
               0: dly = '0;
               1: dly = 24'($urandom);
               default: dly = 24'($urandom_range(0, 150));
            endcase
            case ($urandom_range(0, 7))
               0: loops = 16'($urandom);
               1: loops = '0;
               2: loops = 16'hFFFF;
               default: loops = 16'($urandom_range(1, 6));
            endcase
            yoyo = 1'($urandom_range(0, 1));
         end
      endcase
      set_config(dur, dly, loops, yoyo);

      // time steps sized so legs end every few ticks
      reach = int'((dur == '0) ? 24'd1 : dur) + int'(dly);
      now_t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 2000))
                                          : 32'($urandom);
      it.req_type = REQ_PLAY;
      it.now_ms   = now_t;
      offer(it, 1'b0, QUIET_RSP);
      if (phase == 6) hold_asked <= hold_asked + 1;

      for (int k = 0; k < n_items; k++) begin
         if (phase == 9 && k == n_items / 2) drain_results();
         step  = (reach > 4000) ? 32'($urandom_range(0, 32'h01FF_FFFF))
                                : 32'($urandom_range(0, reach / 5 + 1));
         now_t = now_t + step;
         it.now_ms = now_t;
         pick = $urandom_range(0, 99);
         if (!tl_active && pick < 85) it.req_type = REQ_PLAY;
         else if (pick < 68) it.req_type = REQ_TICK;
         else if (pick < 74) it.req_type = REQ_PAUSE;
         else if (pick < 80) it.req_type = REQ_RESUME;
         else if (pick < 84) it.req_type = REQ_PLAY;
         else if (pick < 88) it.req_type = REQ_STOP;
         else if (pick < 92) it.req_type = REQ_CANCEL;
         else if (pick < 95) it.req_type = pick[0] ? REQ_BAD_HI : REQ_BAD_LO;
         else if (pick < 97) begin
            // clock stepping backwards
            it.req_type = REQ_TICK;
            it.now_ms   = now_t - 32'($urandom_range(1, 50));
         end else begin
            it.req_type = 3'($urandom_range(0, 7));
            it.now_ms   = 32'($urandom);
         end
         offer(it, 1'b0, QUIET_RSP);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result checking and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_item);
               mismatches++;
            end else begin
               rsp_want = pending_rsp.pop_front();
               check_field("ramp_value", 32'(rsp_want.ramp_value), 32'(rsp_item.ramp_value));
               check_field("value_valid", 32'(rsp_want.value_valid), 32'(rsp_item.value_valid));
               check_field("time_progress", 32'(rsp_want.time_progress),
                           32'(rsp_item.time_progress));
               check_field("is_live", 32'(rsp_want.is_live), 32'(rsp_item.is_live));
               check_field("is_paused", 32'(rsp_want.is_paused), 32'(rsp_item.is_paused));
               check_field("going_back", 32'(rsp_want.going_back), 32'(rsp_item.going_back));
               check_field("event_code", 32'(rsp_want.event_code), 32'(rsp_item.event_code));
            end
         end

         // long hold-off on request, otherwise a pattern that changes now and then
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_BEAT);
            mode_left  = $urandom_range(40, 300);
         end
         mode_left--;
         rsp_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (stall_mode)
               STALL_NONE:  stall_next = 1'b0;
               STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
               default:     stall_next = ((rsp_cycle % 7) < 3);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      timeline_reset();

      // idle requests at reset settings, then a one-ms leg across the time wrap
      plan.push_back(fixed_row(REQ_TICK, 32'h0000_0000, QUIET_RSP));
      plan.push_back(fixed_row(REQ_PAUSE, 32'h1234_5678, QUIET_RSP));
      plan.push_back(fixed_row(REQ_STOP, 32'h8000_0000, QUIET_RSP));
      plan.push_back(fixed_row(REQ_CANCEL, 32'h0000_0100, QUIET_RSP));
      plan.push_back(fixed_row(REQ_BAD_LO, 32'h0000_0200, QUIET_RSP));
      plan.push_back(fixed_row(REQ_BAD_HI, 32'hFFFF_FFFF, QUIET_RSP));
      plan.push_back(fixed_row(REQ_PLAY, 32'hFFFF_FFFF,
                               rsp_of('0, 1'b0, '0, 1'b1, 1'b0, 1'b0, EVT_STARTED)));
      plan.push_back(fixed_row(REQ_TICK, 32'h0000_0000,
                               rsp_of(ONE_Q, 1'b1, ONE_Q, 1'b0, 1'b0, 1'b0, EVT_FINISHED)));

      // delay, pause and resume, yoyo reverse leg, restart while live, cancel, stop
      plan.push_back(cfg_row(24'd1000, 24'd100, 16'd3, 1'b1));
      plan.push_back(req_row(REQ_PLAY, 32'd5000));
      plan.push_back(req_row(REQ_TICK, 32'd5050));
      plan.push_back(req_row(REQ_TICK, 32'd5600));
      plan.push_back(req_row(REQ_PAUSE, 32'd5700));
      plan.push_back(req_row(REQ_PAUSE, 32'd5800));
      plan.push_back(req_row(REQ_TICK, 32'd6000));
      plan.push_back(req_row(REQ_RESUME, 32'd9000));
      plan.push_back(req_row(REQ_TICK, 32'd9600));
      plan.push_back(req_row(REQ_TICK, 32'd10000));
      plan.push_back(req_row(REQ_PLAY, 32'd10100));
      plan.push_back(req_row(REQ_CANCEL, 32'd10900));
      plan.push_back(req_row(REQ_PLAY, 32'd20000));
      plan.push_back(fixed_row(REQ_STOP, 32'd20010,
                               rsp_of('0, 1'b0, ONE_Q, 1'b0, 1'b0, 1'b0, EVT_FINISHED)));

      // widest settings with a zero loop counter and a far-off clock
      plan.push_back(cfg_row(24'hFFFFFF, 24'hFFFFFF, 16'd0, 1'b0));
      plan.push_back(req_row(REQ_PLAY, 32'h0000_0000));
      plan.push_back(req_row(REQ_TICK, 32'h00FF_FFFF));
      plan.push_back(req_row(REQ_TICK, 32'hFFFF_FFFF));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) set_config(plan[i].dur, plan[i].dly, plan[i].loops, plan[i].yoyo);
         else offer(plan[i].item, plan[i].typed, plan[i].want);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) run_phase(p, ITEMS_PER_PHASE);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
